[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Each assumes clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define R2_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define R2_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define R2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define R2_ASSERT(lbl, expr)
`define R2_ASSERT_IMP(lbl, ante, cons)
`define R2_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/r2fft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared constants, types and the twiddle cosine generator for the FFT block.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int DATA_W = 28;
  localparam int OUT_W  = 27;
  localparam int CFG_W  = 4;

  localparam logic CFG_IDX_LOG2 = 1'b0;
  localparam logic CFG_IDX_INV  = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [OUT_W-1:0]  out_t;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Unsigned long division by shift and subtract, used only to build the table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Rounded cos(2*pi*m/2^maxl) scaled by 2^twfrac, from a Taylor series in Q60.
  function automatic logic [31:0] tw_cos(input int m, input int maxl, input int twfrac);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        dv;
    logic [63:0]        rnd;
    x    = mul_q60(PI_Q60, 64'(m) << (61 - maxl));
    x2   = mul_q60(x, x);
    term = ONE_Q60;
    sum  = ONE_Q60;
    for (int n = 1; n <= 24; n++) begin
      dv   = 64'((2 * n - 1) * (2 * n));
      term = udiv64(mul_q60(term, x2), dv);
      if (term == 64'd0) break;
      if ((n & 1) == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (sum < 0) sum = '0;
    rnd = (64'(sum) + (64'd1 << (59 - twfrac))) >> (60 - twfrac);
    return rnd[31:0];
  endfunction

  // Clamp a 28-bit word to the 27-bit output range.
  function automatic out_t sat_out(input data_t v);
    out_t r;
    if (v[DATA_W-1] == v[DATA_W-2]) r = v[OUT_W-1:0];
    else if (v[DATA_W-1]) r = {1'b1, {(OUT_W-1){1'b0}}};
    else r = {1'b0, {(OUT_W-1){1'b1}}};
    return r;
  endfunction

endpackage

[src/r2fft_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/r2fft_twiddle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_twiddle
// Twiddle lookup: quarter-wave cosine ROM folded to give cos and -sin.
// ----------------------------------------------------------------------------
module r2fft_twiddle
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_POINTS = 10,
  parameter int TWIDDLE_WIDTH   = 16
) (
  input  logic [MAX_LOG2_POINTS-1:0]   tw_idx,
  output logic signed [TWIDDLE_WIDTH:0] tw_re,
  output logic signed [TWIDDLE_WIDTH:0] tw_im
);

  localparam int CW       = MAX_LOG2_POINTS + 1;
  localparam int QUARTER  = (1 << MAX_LOG2_POINTS) >> 2;
  localparam int HALF     = (1 << MAX_LOG2_POINTS) >> 1;
  localparam int QTR_SIZE = QUARTER + 1;
  localparam int QIW      = (QTR_SIZE > 1) ? $clog2(QTR_SIZE) : 1;

  logic [TWIDDLE_WIDTH-1:0] rom [QTR_SIZE];

  for (genvar m = 0; m < QTR_SIZE; m++) begin : g_rom
    localparam logic [31:0] CV = tw_cos(m, MAX_LOG2_POINTS, TWIDDLE_WIDTH - 1);
    assign rom[m] = CV[TWIDDLE_WIDTH-1:0];
  end

  logic [CW-1:0]            t_w;
  logic                     low_half;
  logic [CW-1:0]            ci_w;
  logic [CW-1:0]            si_w;
  logic [TWIDDLE_WIDTH:0]   c_mag;
  logic [TWIDDLE_WIDTH:0]   s_mag;

  always_comb begin
    t_w      = {1'b0, tw_idx};
    low_half = (t_w <= CW'(QUARTER));
    ci_w     = low_half ? t_w : CW'(HALF) - t_w;
    si_w     = low_half ? CW'(QUARTER) - t_w : t_w - CW'(QUARTER);
    c_mag    = {1'b0, rom[ci_w[QIW-1:0]]};
    s_mag    = {1'b0, rom[si_w[QIW-1:0]]};
    tw_re    = low_half ? signed'(c_mag) : -signed'(c_mag);
    tw_im    = -signed'(s_mag);
  end

endmodule

[src/r2fft_bfly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_bfly
// Butterfly datapath: registered complex product, then sum and difference.
// ----------------------------------------------------------------------------
module r2fft_bfly
  import r2fft_pkg::*;
#(
  parameter int TWIDDLE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         mul_en,
  input  data_t                        xr,
  input  data_t                        xi,
  input  logic signed [TWIDDLE_WIDTH:0] wr,
  input  logic signed [TWIDDLE_WIDTH:0] wi,
  input  data_t                        ar,
  input  data_t                        ai,
  output data_t                        top_re,
  output data_t                        top_im,
  output data_t                        bot_re,
  output data_t                        bot_im
);

  localparam int PW = DATA_W + TWIDDLE_WIDTH + 1;

  logic signed [PW-1:0] rr_r, ii_r, ri_r, ir_r;
  logic signed [PW:0]   sr, si;
  logic signed [PW:0]   shr, shi;
  data_t                pr, pi;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      rr_r <= xr * wr;
      ii_r <= xi * wi;
      ri_r <= xr * wi;
      ir_r <= xi * wr;
    end
  end

  always_comb begin
    sr     = (PW+1)'(rr_r) - (PW+1)'(ii_r);
    si     = (PW+1)'(ri_r) + (PW+1)'(ir_r);
    shr    = sr >>> (TWIDDLE_WIDTH - 1);
    shi    = si >>> (TWIDDLE_WIDTH - 1);
    pr     = shr[DATA_W-1:0];
    pi     = shi[DATA_W-1:0];
    top_re = ar + pr;
    top_im = ai + pi;
    bot_re = ar - pr;
    bot_im = ai - pi;
  end

endmodule

[src/radix2_fft_with_inverse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_with_inverse
// In-place radix-2 DIT FFT / scaled inverse FFT over one sample memory.
// ----------------------------------------------------------------------------
// Usage: write log2_size (index 0) and inverse_mode (index 1) on the cfg port
// while idle. Send N load words (in_kind 0) to fill a frame; the Nth load
// starts the transform, during which in_ready stays low. Then send read words
// (in_kind 1); each returns one bin on the out channel, last_bin on bin N-1,
// after which the block loads again. A read with no frame gives bin_valid 0.
// Loads are accepted one per cycle unless a pending read or a held result
// word stalls the input. A pending read blocks the input; its bin passes
// through the memory read and the output word register. The transform runs
// on one butterfly unit and one memory port pair: conjugation in inverse
// mode, a bit-reverse pass swapping pairs through a hold register, a
// butterfly pass per stage (read a, read b, multiply, write bottom, write top),
// and final scaling in inverse mode. Reset returns to loading with an empty
// frame; the memory is not cleared. A stalled receiver holds the result
// word, and the input stalls until the word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radix2_fft_with_inverse
  import r2fft_pkg::*;
#(
  parameter int MAX_LOG2_POINTS = 10,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int TWIDDLE_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [CFG_W-1:0]               cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_imag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [OUT_W-1:0]        out_bin_real,
  output logic signed [OUT_W-1:0]        out_bin_imag,
  output logic                           out_bin_valid,
  output logic                           out_last_bin
);

  localparam int AW    = MAX_LOG2_POINTS;
  localparam int CW    = MAX_LOG2_POINTS + 1;
  localparam int LGW   = $clog2(MAX_LOG2_POINTS + 1);
  localparam int RAM_W = 2 * DATA_W;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_CONJ  = 3'd1;
  localparam logic [2:0] ST_REV   = 3'd2;
  localparam logic [2:0] ST_BFLY  = 3'd3;
  localparam logic [2:0] ST_POST  = 3'd4;
  localparam logic [2:0] ST_READY = 3'd5;

  logic [CFG_W-1:0] log2_size_r;
  logic             inverse_r;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [LGW-1:0]   stage_r, stage_nxt;
  logic [CW-1:0]    load_cnt_r, load_cnt_nxt;
  logic [CW-1:0]    read_cnt_r, read_cnt_nxt;
  logic [RAM_W-1:0] hold_r, hold_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_last_r, rd_last_nxt;

  logic                        out_valid_r;
  out_t                        out_re_r, out_im_r;
  logic                        out_bv_r, out_last_r;

  logic signed [TWIDDLE_WIDTH:0] tw_re_r, tw_im_r, tw_re_c, tw_im_c;
  logic                          tw_ld, mul_en;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  logic [LGW-1:0] lg_c;
  logic [CW-1:0]  n_c, half_c, a_c, b_c, q_lo, rev_c;
  logic [LGW-1:0] tw_sh;
  logic [AW-1:0]  tw_t;
  logic           in_fire;

  data_t rd_re, rd_im, hold_re, hold_im;
  data_t top_re, top_im, bot_re, bot_im;
  data_t smp_re, smp_im;
  data_t post_re, post_im;
  logic signed [DATA_W:0] neg_im, sh_im;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_size_r <= CFG_W'(10);
      inverse_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_LOG2: log2_size_r <= cfg_wdata;
        CFG_IDX_INV:  inverse_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (log2_size_r == '0) lg_c = LGW'(1);
    else if (32'(log2_size_r) > MAX_LOG2_POINTS) lg_c = LGW'(MAX_LOG2_POINTS);
    else lg_c = log2_size_r[LGW-1:0];
  end

  assign n_c    = CW'(1) << lg_c;
  assign half_c = CW'(1) << stage_r;

  // butterfly addresses: insert a zero bit at the stage position of the count
  always_comb begin
    q_lo  = idx_r & (half_c - CW'(1));
    a_c   = ((idx_r >> stage_r) << (stage_r + LGW'(1))) | q_lo;
    b_c   = a_c | half_c;
    tw_sh = LGW'(MAX_LOG2_POINTS - 1) - stage_r;
    tw_t  = AW'(q_lo << tw_sh);
  end

  always_comb begin
    rev_c = '0;
    for (int m = 0; m < MAX_LOG2_POINTS; m++) begin
      if (m < int'(lg_c)) rev_c[m] = idx_r[int'(lg_c) - 1 - m];
    end
  end

  assign rd_re   = ram_rdata[RAM_W-1:DATA_W];
  assign rd_im   = ram_rdata[DATA_W-1:0];
  assign hold_re = hold_r[RAM_W-1:DATA_W];
  assign hold_im = hold_r[DATA_W-1:0];
  assign smp_re  = DATA_W'(in_sample_real);
  assign smp_im  = DATA_W'(in_sample_imag);

  always_comb begin
    post_re = rd_re >>> lg_c;
    neg_im  = -(DATA_W+1)'(rd_im);
    sh_im   = neg_im >>> lg_c;
    post_im = sh_im[DATA_W-1:0];
  end

  assign in_ready = (state_r == ST_LOAD || state_r == ST_READY) && !rd_pend_r
                    && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    idx_nxt      = idx_r;
    stage_nxt    = stage_r;
    load_cnt_nxt = load_cnt_r;
    read_cnt_nxt = read_cnt_r;
    hold_nxt     = hold_r;
    rd_pend_nxt  = 1'b0;
    rd_vld_nxt   = rd_vld_r;
    rd_last_nxt  = rd_last_r;
    ram_we       = 1'b0;
    ram_waddr    = idx_r[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx_r[AW-1:0];
    tw_ld        = 1'b0;
    mul_en       = 1'b0;
    case (state_r)
      ST_LOAD, ST_READY: begin
        ram_raddr = read_cnt_r[AW-1:0];
        if (in_fire) begin
          if (!in_kind) begin
            if (state_r == ST_LOAD) begin
              ram_we    = 1'b1;
              ram_waddr = load_cnt_r[AW-1:0];
              ram_wdata = {smp_re, smp_im};
              if (load_cnt_r + CW'(1) >= n_c) begin
                load_cnt_nxt = '0;
                step_nxt     = '0;
                state_nxt    = inverse_r ? ST_CONJ : ST_REV;
                idx_nxt      = inverse_r ? CW'(0) : CW'(1);
              end else begin
                load_cnt_nxt = load_cnt_r + CW'(1);
              end
            end
          end else begin
            rd_pend_nxt = 1'b1;
            if (state_r == ST_READY) begin
              rd_vld_nxt  = 1'b1;
              rd_last_nxt = (read_cnt_r + CW'(1) >= n_c);
              if (read_cnt_r + CW'(1) >= n_c) begin
                read_cnt_nxt = '0;
                state_nxt    = ST_LOAD;
              end else begin
                read_cnt_nxt = read_cnt_r + CW'(1);
              end
            end else begin
              rd_vld_nxt  = 1'b0;
              rd_last_nxt = 1'b0;
            end
          end
        end
      end
      ST_CONJ: begin
        if (step_r == 3'd0) begin
          step_nxt = 3'd1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {rd_re, -rd_im};
          step_nxt  = 3'd0;
          if (idx_r == n_c - CW'(1)) begin
            state_nxt = ST_REV;
            idx_nxt   = CW'(1);
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      ST_REV: begin
        case (step_r)
          3'd0: begin
            if (idx_r + CW'(1) >= n_c) begin
              state_nxt = ST_BFLY;
              idx_nxt   = '0;
              stage_nxt = '0;
            end else if (idx_r < rev_c) begin
              step_nxt = 3'd1;
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
          3'd1: begin
            ram_raddr = rev_c[AW-1:0];
            hold_nxt  = ram_rdata;
            step_nxt  = 3'd2;
          end
          3'd2: begin
            ram_we   = 1'b1;
            step_nxt = 3'd3;
          end
          default: begin
            ram_we    = 1'b1;
            ram_waddr = rev_c[AW-1:0];
            ram_wdata = hold_r;
            step_nxt  = 3'd0;
            idx_nxt   = idx_r + CW'(1);
          end
        endcase
      end
      ST_BFLY: begin
        case (step_r)
          3'd0: begin
            ram_raddr = a_c[AW-1:0];
            tw_ld     = 1'b1;
            step_nxt  = 3'd1;
          end
          3'd1: begin
            ram_raddr = b_c[AW-1:0];
            hold_nxt  = ram_rdata;
            step_nxt  = 3'd2;
          end
          3'd2: begin
            mul_en   = 1'b1;
            step_nxt = 3'd3;
          end
          3'd3: begin
            ram_we    = 1'b1;
            ram_waddr = b_c[AW-1:0];
            ram_wdata = {bot_re, bot_im};
            step_nxt  = 3'd4;
          end
          default: begin
            ram_we    = 1'b1;
            ram_waddr = a_c[AW-1:0];
            ram_wdata = {top_re, top_im};
            step_nxt  = 3'd0;
            if (idx_r == (n_c >> 1) - CW'(1)) begin
              idx_nxt = '0;
              if (stage_r == lg_c - LGW'(1)) begin
                state_nxt    = inverse_r ? ST_POST : ST_READY;
                read_cnt_nxt = '0;
              end else begin
                stage_nxt = stage_r + LGW'(1);
              end
            end else begin
              idx_nxt = idx_r + CW'(1);
            end
          end
        endcase
      end
      ST_POST: begin
        if (step_r == 3'd0) begin
          step_nxt = 3'd1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {post_re, post_im};
          step_nxt  = 3'd0;
          if (idx_r == n_c - CW'(1)) begin
            state_nxt    = ST_READY;
            read_cnt_nxt = '0;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      step_r     <= '0;
      idx_r      <= '0;
      stage_r    <= '0;
      load_cnt_r <= '0;
      read_cnt_r <= '0;
      rd_pend_r  <= 1'b0;
      rd_vld_r   <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      idx_r      <= idx_nxt;
      stage_r    <= stage_nxt;
      load_cnt_r <= load_cnt_nxt;
      read_cnt_r <= read_cnt_nxt;
      rd_pend_r  <= rd_pend_nxt;
      rd_vld_r   <= rd_vld_nxt;
      rd_last_r  <= rd_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (tw_ld) begin
      tw_re_r <= tw_re_c;
      tw_im_r <= tw_im_c;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_re_r   <= rd_vld_r ? sat_out(rd_re) : '0;
      out_im_r   <= rd_vld_r ? sat_out(rd_im) : '0;
      out_bv_r   <= rd_vld_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_real  = out_re_r;
  assign out_bin_imag  = out_im_r;
  assign out_bin_valid = out_bv_r;
  assign out_last_bin  = out_last_r;

  r2fft_ram #(
    .WIDTH(RAM_W),
    .DEPTH(1 << MAX_LOG2_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  r2fft_twiddle #(
    .MAX_LOG2_POINTS(MAX_LOG2_POINTS),
    .TWIDDLE_WIDTH  (TWIDDLE_WIDTH)
  ) u_twiddle (
    .tw_idx(tw_t),
    .tw_re (tw_re_c),
    .tw_im (tw_im_c)
  );

  r2fft_bfly #(
    .TWIDDLE_WIDTH(TWIDDLE_WIDTH)
  ) u_bfly (
    .clk   (clk),
    .mul_en(mul_en),
    .xr    (rd_re),
    .xi    (rd_im),
    .wr    (tw_re_r),
    .wi    (tw_im_r),
    .ar    (hold_re),
    .ai    (hold_im),
    .top_re(top_re),
    .top_im(top_im),
    .bot_re(bot_re),
    .bot_im(bot_im)
  );

  `R2_ASSERT_IMP(a_busy_no_accept, state_r != ST_LOAD && state_r != ST_READY, !in_ready)
  `R2_ASSERT_NEXT(a_read_to_out, rd_pend_r, out_valid_r)
  `R2_ASSERT_IMP(a_slot_free, rd_pend_r, !out_valid_r)
  `R2_ASSERT_IMP(a_bfly_step, state_r == ST_BFLY, step_r <= 3'd4)

endmodule
